/* sv/eafp_pkg.sv */
package eafp_pkg;

    localparam int ScreenWidthDef  = 1024;
    localparam int ScreenHeightDef = 1024;

    typedef enum logic [2:0] {
        REG_CENTER_X = 3'd0,
        REG_CENTER_Y = 3'd1,
        REG_RADIUS_X = 3'd2,
        REG_RADIUS_Y = 3'd3,
        REG_FILL     = 3'd4,
        REG_OPACITY  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [9:0]  pixel_x;
        logic [9:0]  pixel_y;
        logic [31:0] pixel_value;
    } t_pix_in;

    typedef struct packed {
        logic [31:0] pixel_result;
        logic        inside_res;
    } t_pix_out;

    // weights reach 256 at the ends of the opacity range
    typedef struct packed {
        logic [8:0] a;
        logic [8:0] b;
    } t_wts;

    // blend weights: a = p*256/100, b = (100-p)*256/100, p clamped at 100
    // p*64/25 is taken as (p*64*5243) >> 17, exact for p up to 100
    function automatic t_wts blend_wts(input logic [6:0] p_raw);
        logic [6:0]  p;
        logic [6:0]  q;
        logic [25:0] pa;
        logic [25:0] pb;
        t_wts        w;
        p = (p_raw > 7'd100) ? 7'd100 : p_raw;
        q = 7'd100 - p;
        pa = 26'({p, 6'b0}) * 26'd5243;
        pb = 26'({q, 6'b0}) * 26'd5243;
        w.a = pa[25:17];
        w.b = pb[25:17];
        return w;
    endfunction

endpackage

/* sv/ellipse_alpha_fill_pixel.sv */
// Each accepted input beat yields its result beat after passing all four registered cells.
// Throughput: one pixel per cycle; the four-cell chain advances whenever the
// last cell is empty or its beat is taken (one global stall enable).
// Cells: differences, squares, products, compare+blend.
// Reset: synchronous active low; clears valid bits and all config registers.
module ellipse_alpha_fill_pixel
    import eafp_pkg::*;
#(
    parameter int SCREEN_WIDTH  = ScreenWidthDef,
    parameter int SCREEN_HEIGHT = ScreenHeightDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_pix_in     i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_pix_out    o_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    logic signed [12:0] r_cx, r_cy;
    logic [11:0] r_rx, r_ry;
    logic [23:0] r_fill;
    logic [6:0]  r_op;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0; r_cy <= '0; r_rx <= '0; r_ry <= '0;
            r_fill <= '0; r_op <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CENTER_X: r_cx   <= i_cfg_data[12:0];
                REG_CENTER_Y: r_cy   <= i_cfg_data[12:0];
                REG_RADIUS_X: r_rx   <= i_cfg_data[11:0];
                REG_RADIUS_Y: r_ry   <= i_cfg_data[11:0];
                REG_FILL:     r_fill <= i_cfg_data[23:0];
                REG_OPACITY:  r_op   <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic v1, v2, v3, v4;
    assign en      = !v4 || i_ready;
    assign o_ready = en;

    // cell 1: magnitudes
    typedef struct packed {
        logic [31:0] pix;
        logic        ok;
        logic        dx0;
        logic [13:0] adx;
        logic [13:0] ady;
    } t_s1;
    t_s1 s1_n, s1_q;
    logic signed [14:0] dx, dy;
    always_comb begin
        dx = 15'($signed({1'b0, i_data.pixel_x})) - 15'(r_cx);
        dy = 15'($signed({1'b0, i_data.pixel_y})) - 15'(r_cy);
        s1_n.pix = i_data.pixel_value;
        s1_n.adx = dx[14] ? 14'(-dx) : dx[13:0];
        s1_n.ady = dy[14] ? 14'(-dy) : dy[13:0];
        s1_n.dx0 = (dx == '0);
        s1_n.ok  = (r_rx != '0) && (r_ry != '0)
                && (32'(i_data.pixel_x) < 32'(SCREEN_WIDTH))
                && (32'(i_data.pixel_y) < 32'(SCREEN_HEIGHT))
                && ({2'b0, r_ry} >= s1_n.ady);
    end
    eafp_cell #(.W($bits(t_s1))) u_c1 (.i_clk, .i_rst_n, .i_en(en),
        .i_valid(i_valid), .i_data(s1_n), .o_valid(v1), .o_data(s1_q));

    // cell 2: t^2, ry^2-dy^2, rx^2
    typedef struct packed {
        logic [31:0] pix;
        logic        ok;
        logic        dx0;
        logic [29:0] t2;
        logic [23:0] ry2;
        logic [23:0] dd;
        logic [23:0] rx2;
    } t_s2;
    t_s2 s2_n, s2_q;
    logic [14:0] t;
    always_comb begin
        t = {s1_q.adx, 1'b0} - 15'd1;
        s2_n.pix = s1_q.pix;
        s2_n.ok  = s1_q.ok;
        s2_n.dx0 = s1_q.dx0;
        s2_n.t2  = 30'(t) * 30'(t);
        s2_n.ry2 = 24'(r_ry) * 24'(r_ry);
        s2_n.dd  = 24'(r_ry) * 24'(r_ry) - 24'(s1_q.ady[11:0]) * 24'(s1_q.ady[11:0]);
        s2_n.rx2 = 24'(r_rx) * 24'(r_rx);
    end
    eafp_cell #(.W($bits(t_s2))) u_c2 (.i_clk, .i_rst_n, .i_en(en),
        .i_valid(v1), .i_data(s2_n), .o_valid(v2), .o_data(s2_q));

    // cell 3: lhs and rhs (each a single product kept in a 54-bit and a 50-bit
    // result; one multiply per operand pair)
    typedef struct packed {
        logic [31:0] pix;
        logic        ok;
        logic        dx0;
        logic [53:0] lhs;
        logic [49:0] rhs;
    } t_s3;
    t_s3 s3_n, s3_q;
    always_comb begin
        s3_n.pix = s2_q.pix;
        s3_n.ok  = s2_q.ok;
        s3_n.dx0 = s2_q.dx0;
        s3_n.lhs = 54'(s2_q.t2) * 54'(s2_q.ry2);
        s3_n.rhs = {50'(s2_q.rx2) * 50'(s2_q.dd)} << 2;
    end
    eafp_cell #(.W($bits(t_s3))) u_c3 (.i_clk, .i_rst_n, .i_en(en),
        .i_valid(v2), .i_data(s3_n), .o_valid(v3), .o_data(s3_q));

    // cell 4: compare and blend
    t_pix_out s4_n;
    t_wts     w;
    logic     ins;
    logic [15:0] mix [4];
    logic [7:0]  fb  [4];
    always_comb begin
        w   = blend_wts(r_op);
        ins = s3_q.ok && (s3_q.dx0 || (55'(s3_q.lhs) <= 55'(s3_q.rhs)));
        fb[0] = r_fill[7:0];
        fb[1] = r_fill[15:8];
        fb[2] = r_fill[23:16];
        fb[3] = 8'd0;
        for (int k = 0; k < 4; k++) begin
            mix[k] = (16'(s3_q.pix[8*k +: 8]) * 16'(w.b)
                   + 16'(fb[k]) * 16'(w.a)) >> 8;
            s4_n.pixel_result[8*k +: 8] = ins ? ((mix[k] > 16'd255) ? 8'd255
                                                  : mix[k][7:0])
                                              : s3_q.pix[8*k +: 8];
        end
        s4_n.inside_res = ins;
    end
    eafp_cell #(.W($bits(t_pix_out))) u_c4 (.i_clk, .i_rst_n, .i_en(en),
        .i_valid(v3), .i_data(s4_n), .o_valid(v4), .o_data(o_data));

    assign o_valid = v4;

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("result changed under stall");
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("accepted beat into full chain");
    a_inside_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.inside_res) |-> ($past(r_rx) != '0))
        else $error("inside with zero radius");
endmodule

/* sv/eafp_cell.sv */
// One pipeline cell: registers a payload word and valid, holds both while the enable is low.
module eafp_cell #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    output logic [W-1:0] o_data
);
    logic         r_valid;
    logic [W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule
